// ===== sv/cursor_sequence_buffer_assert.svh =====
// ----------------------------------------------------------------------------
// cursor_sequence_buffer_assert
// assertion macros for the cursor sequence buffer checker
// ----------------------------------------------------------------------------
`ifndef CURSOR_SEQUENCE_BUFFER_ASSERT_SVH
`define CURSOR_SEQUENCE_BUFFER_ASSERT_SVH

// same-cycle implication
`define CSB_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("cursor_sequence_buffer assertion failed");

// next-cycle implication
`define CSB_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("cursor_sequence_buffer assertion failed");

`endif

// ===== sv/csb_pkg.sv =====
// ----------------------------------------------------------------------------
// csb_pkg
// types, sizes and codes of the cursor sequence buffer
// ----------------------------------------------------------------------------
package csb_pkg;

    localparam int CAPACITY   = 64;
    localparam int VALUE_BITS = 32;

    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int GROUP_SIZE = 8;
    localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

    localparam int FUNC_W     = 3;
    localparam int IN_DATA_W  = 32;
    localparam int CUR_W      = 32;
    localparam int COUNT_W    = 7;
    localparam int STATUS_W   = 2;

    localparam int OUT_HAS_BIT = 0;
    localparam int OUT_VAL_LSB = 1;
    localparam int OUT_CNT_LSB = OUT_VAL_LSB + CUR_W;
    localparam int OUT_ST_LSB  = OUT_CNT_LSB + COUNT_W;
    localparam int OUT_USED_W  = OUT_ST_LSB + STATUS_W;
    localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic [FUNC_W-1:0] {
        FN_START   = 3'd0,
        FN_ADVANCE = 3'd1,
        FN_INSERT  = 3'd2,
        FN_ATTACH  = 3'd3,
        FN_REMOVE  = 3'd4,
        FN_QUERY   = 3'd5
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_NOCUR = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GATHER,
        S_MERGE
    } t_state;

    typedef enum logic [1:0] {
        SH_HOLD,
        SH_UP,
        SH_DOWN
    } t_shift;

    typedef struct packed {
        t_shift                  mode;
        logic [CNT_W-1:0]        pos;
        logic [VALUE_BITS-1:0]   data;
        logic                    tap_en;
        logic [CNT_W-1:0]        tap_pos;
    } t_cell_cmd;

endpackage

// ===== sv/cursor_sequence_buffer.sv =====
// ----------------------------------------------------------------------------
// cursor_sequence_buffer
// ordered list of values with a cursor, held in a row of shifting cells
// ----------------------------------------------------------------------------
// the input word is taken in S_IDLE, S_GATHER registers the group or-terms of the
//   two-level or-tree that reads the current cell, and S_MERGE registers the result
//   word; no new word is taken until the last one has left S_MERGE
// a full result register waiting on m_axis_tready holds the merge step
// reset: synchronous active low, clears count, cursor, fsm and output valid;
//   cell contents are not reset
module cursor_sequence_buffer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [csb_pkg::IN_DATA_W-1:0]        s_axis_tdata,  // entry_value
    input  logic [csb_pkg::FUNC_W-1:0]           s_axis_tuser,  // func
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // has_current, current_value, entry_count, status, zero pad
    output logic [csb_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);

    localparam int TAP_N = csb_pkg::NUM_GROUPS * csb_pkg::GROUP_SIZE;

    csb_pkg::t_cell_cmd               w_cmd;
    logic                             w_gather;
    logic [csb_pkg::VALUE_BITS-1:0]   w_value [csb_pkg::CAPACITY];
    logic [csb_pkg::VALUE_BITS-1:0]   w_tap   [TAP_N];
    logic [csb_pkg::VALUE_BITS-1:0]   r_grp   [csb_pkg::NUM_GROUPS];
    logic [csb_pkg::VALUE_BITS-1:0]   n_grp   [csb_pkg::NUM_GROUPS];
    logic [csb_pkg::VALUE_BITS-1:0]   w_cur_value;

    csb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_func   (s_axis_tuser),
        .i_in_data   (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .i_cur_value (w_cur_value),
        .o_cmd       (w_cmd),
        .o_gather    (w_gather)
    );

    for (genvar i = 0; i < csb_pkg::CAPACITY; i++) begin : g_cell
        logic [csb_pkg::VALUE_BITS-1:0] w_lower;
        logic [csb_pkg::VALUE_BITS-1:0] w_upper;

        if (i == 0) begin : g_first
            assign w_lower = '0;
        end else begin : g_mid_lo
            assign w_lower = w_value[i-1];
        end

        if (i == csb_pkg::CAPACITY - 1) begin : g_last
            assign w_upper = '0;
        end else begin : g_mid_hi
            assign w_upper = w_value[i+1];
        end

        csb_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (csb_pkg::CNT_W'(i)),
            .i_cmd   (w_cmd),
            .i_lower (w_lower),
            .i_upper (w_upper),
            .o_value (w_value[i]),
            .o_tap   (w_tap[i])
        );
    end

    for (genvar i = csb_pkg::CAPACITY; i < TAP_N; i++) begin : g_pad
        assign w_tap[i] = '0;
    end

    for (genvar g = 0; g < csb_pkg::NUM_GROUPS; g++) begin : g_group
        always_comb begin
            n_grp[g] = '0;
            for (int j = 0; j < csb_pkg::GROUP_SIZE; j++) begin
                n_grp[g] = n_grp[g] | w_tap[g * csb_pkg::GROUP_SIZE + j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_gather) begin
                r_grp[g] <= n_grp[g];
            end
        end
    end

    always_comb begin
        w_cur_value = '0;
        for (int g = 0; g < csb_pkg::NUM_GROUPS; g++) begin
            w_cur_value = w_cur_value | r_grp[g];
        end
    end

endmodule

// ===== sv/csb_cell.sv =====
// ----------------------------------------------------------------------------
// csb_cell
// one list slot: holds, shifts up, shifts down or loads a new word
// ----------------------------------------------------------------------------
module csb_cell (
    input  logic                                 i_clk,
    input  logic [csb_pkg::CNT_W-1:0]            i_idx,
    input  csb_pkg::t_cell_cmd                   i_cmd,
    input  logic [csb_pkg::VALUE_BITS-1:0]       i_lower,
    input  logic [csb_pkg::VALUE_BITS-1:0]       i_upper,
    output logic [csb_pkg::VALUE_BITS-1:0]       o_value,
    output logic [csb_pkg::VALUE_BITS-1:0]       o_tap
);

    logic [csb_pkg::VALUE_BITS-1:0] r_value;
    logic [csb_pkg::VALUE_BITS-1:0] n_value;

    always_comb begin
        n_value = r_value;
        case (i_cmd.mode)
            csb_pkg::SH_UP: begin
                if (i_idx > i_cmd.pos) begin
                    n_value = i_lower;
                end else if (i_idx == i_cmd.pos) begin
                    n_value = i_cmd.data;
                end
            end
            csb_pkg::SH_DOWN: begin
                if (i_idx >= i_cmd.pos) begin
                    n_value = i_upper;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_tap   = (i_cmd.tap_en && (i_idx == i_cmd.tap_pos)) ? r_value : '0;

endmodule

// ===== sv/csb_ctrl.sv =====
// ----------------------------------------------------------------------------
// csb_ctrl
// cursor and count bookkeeping, shift commands and result handshake
// ----------------------------------------------------------------------------
module csb_ctrl (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [csb_pkg::FUNC_W-1:0]           i_in_func,
    input  logic [csb_pkg::IN_DATA_W-1:0]        i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [csb_pkg::OUT_DATA_W-1:0]       o_out_data,
    input  logic [csb_pkg::VALUE_BITS-1:0]       i_cur_value,
    output csb_pkg::t_cell_cmd                   o_cmd,
    output logic                                 o_gather
);

    csb_pkg::t_state                r_state;
    csb_pkg::t_state                n_state;
    logic [csb_pkg::CNT_W-1:0]      r_cursor;
    logic [csb_pkg::CNT_W-1:0]      n_cursor;
    logic [csb_pkg::CNT_W-1:0]      r_count;
    logic [csb_pkg::CNT_W-1:0]      n_count;
    logic                           r_has;
    logic                           n_has;
    csb_pkg::t_status               r_status;
    csb_pkg::t_status               n_status;
    logic                           r_out_valid;
    logic [csb_pkg::OUT_DATA_W-1:0] r_out_data;
    logic [csb_pkg::OUT_DATA_W-1:0] n_out_data;
    logic                           w_accept;
    logic                           w_load;
    logic                           w_present;
    logic                           w_full;

    assign w_accept  = i_in_valid && o_in_ready;
    assign w_present = r_cursor < r_count;
    assign w_full    = r_count == csb_pkg::CAP_CNT;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            csb_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = csb_pkg::S_GATHER;
                end
            end
            csb_pkg::S_GATHER: begin
                n_state = csb_pkg::S_MERGE;
            end
            csb_pkg::S_MERGE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = csb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = csb_pkg::S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_gather   = 1'b0;
        w_load     = 1'b0;
        case (r_state)
            csb_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
            end
            csb_pkg::S_GATHER: begin
                o_gather = 1'b1;
            end
            csb_pkg::S_MERGE: begin
                w_load = !r_out_valid || i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // list operation
    always_comb begin
        n_cursor       = r_cursor;
        n_count        = r_count;
        n_status       = csb_pkg::ST_DONE;
        o_cmd.mode     = csb_pkg::SH_HOLD;
        o_cmd.pos      = r_cursor;
        o_cmd.data     = csb_pkg::VALUE_BITS'(i_in_data);
        o_cmd.tap_en   = r_has;
        o_cmd.tap_pos  = r_cursor;
        if (w_accept) begin
            case (csb_pkg::t_func'(i_in_func))
                csb_pkg::FN_START: begin
                    n_cursor = '0;
                end
                csb_pkg::FN_ADVANCE: begin
                    if (!w_present) begin
                        n_status = csb_pkg::ST_NOCUR;
                    end else begin
                        n_cursor = csb_pkg::CNT_W'(r_cursor + 1'b1);
                    end
                end
                csb_pkg::FN_INSERT: begin
                    if (w_full) begin
                        n_status = csb_pkg::ST_FULL;
                    end else begin
                        n_cursor   = w_present ? r_cursor : '0;
                        n_count    = csb_pkg::CNT_W'(r_count + 1'b1);
                        o_cmd.mode = csb_pkg::SH_UP;
                        o_cmd.pos  = n_cursor;
                    end
                end
                csb_pkg::FN_ATTACH: begin
                    if (w_full) begin
                        n_status = csb_pkg::ST_FULL;
                    end else begin
                        n_cursor   = w_present ? csb_pkg::CNT_W'(r_cursor + 1'b1) : r_count;
                        n_count    = csb_pkg::CNT_W'(r_count + 1'b1);
                        o_cmd.mode = csb_pkg::SH_UP;
                        o_cmd.pos  = n_cursor;
                    end
                end
                csb_pkg::FN_REMOVE: begin
                    if (!w_present) begin
                        n_status = csb_pkg::ST_NOCUR;
                    end else begin
                        n_count    = csb_pkg::CNT_W'(r_count - 1'b1);
                        o_cmd.mode = csb_pkg::SH_DOWN;
                        o_cmd.pos  = r_cursor;
                    end
                end
                default: begin
                    n_cursor = r_cursor;
                end
            endcase
        end
        n_has = n_cursor < n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= csb_pkg::S_IDLE;
            r_cursor    <= '0;
            r_count     <= '0;
            r_has       <= 1'b0;
            r_status    <= csb_pkg::ST_DONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_cursor <= n_cursor;
                r_count  <= n_count;
                r_has    <= n_has;
                r_status <= n_status;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_out_data = '0;
        n_out_data[csb_pkg::OUT_HAS_BIT] = r_has;
        n_out_data[csb_pkg::OUT_VAL_LSB +: csb_pkg::CUR_W] = csb_pkg::CUR_W'(i_cur_value);
        n_out_data[csb_pkg::OUT_CNT_LSB +: csb_pkg::COUNT_W] = csb_pkg::COUNT_W'(r_count);
        n_out_data[csb_pkg::OUT_ST_LSB +: csb_pkg::STATUS_W] = r_status;
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== sv/csb_checker.sv =====
// ----------------------------------------------------------------------------
// csb_checker
// port-level checks of the cursor sequence buffer, bound to the top level
// ----------------------------------------------------------------------------
`include "cursor_sequence_buffer_assert.svh"

module csb_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    input  logic                                 s_axis_tready,
    input  logic [csb_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    input  logic [csb_pkg::FUNC_W-1:0]           s_axis_tuser,
    input  logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic [csb_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);

    logic                           w_has;
    logic [csb_pkg::CUR_W-1:0]      w_val;
    logic [csb_pkg::COUNT_W-1:0]    w_cnt;
    logic [csb_pkg::STATUS_W-1:0]   w_st;
    logic                           w_in_take;

    assign w_has     = m_axis_tdata[csb_pkg::OUT_HAS_BIT];
    assign w_val     = m_axis_tdata[csb_pkg::OUT_VAL_LSB +: csb_pkg::CUR_W];
    assign w_cnt     = m_axis_tdata[csb_pkg::OUT_CNT_LSB +: csb_pkg::COUNT_W];
    assign w_st      = m_axis_tdata[csb_pkg::OUT_ST_LSB +: csb_pkg::STATUS_W];
    assign w_in_take = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata)
                       && (s_axis_tuser == s_axis_tuser);

    `CSB_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `CSB_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    `CSB_ASSERT_IMP(a_status_code, i_clk, i_rst_n, m_axis_tvalid, w_st <= csb_pkg::ST_NOCUR)
    `CSB_ASSERT_IMP(a_no_cur_zero, i_clk, i_rst_n, m_axis_tvalid && !w_has, w_val == '0)
    `CSB_ASSERT_NXT(a_busy_after_take, i_clk, i_rst_n, w_in_take, !s_axis_tready)

endmodule

bind cursor_sequence_buffer csb_checker u_csb_checker (.*);

// ===== verif/tb_cursor_sequence_buffer.sv =====
// ----------------------------------------------------------------------------
// tb_cursor_sequence_buffer
// drives list operations into the cursor sequence buffer under random stalls
// on both streams; a list model in the scoreboard predicts the cursor view,
// entry count and status of every word, and each result word is compared
// with the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

typedef struct {
    logic                           has_cur;
    logic [csb_pkg::CUR_W-1:0]      value;
    logic [csb_pkg::COUNT_W-1:0]    count;
    csb_pkg::t_status               status;
} t_cursor_view;

class seq_scoreboard;
    logic [csb_pkg::VALUE_BITS-1:0] entries[$];
    int unsigned                    cursor;
    t_cursor_view                   views[$];
    int                             errors;

    function new();
        cursor = 0;
        errors = 0;
    endfunction

    function int outstanding();
        return views.size();
    endfunction

    function void note_word(logic [csb_pkg::FUNC_W-1:0] fn,
                            logic [csb_pkg::IN_DATA_W-1:0] val);
        t_cursor_view v;
        logic         present;
        logic         full;
        present  = cursor < entries.size();
        full     = entries.size() >= csb_pkg::CAPACITY;
        v.status = csb_pkg::ST_DONE;
        case (fn)
            csb_pkg::FN_START: begin
                cursor = 0;
            end
            csb_pkg::FN_ADVANCE: begin
                if (!present) v.status = csb_pkg::ST_NOCUR;
                else cursor++;
            end
            csb_pkg::FN_INSERT: begin
                if (full) begin
                    v.status = csb_pkg::ST_FULL;
                end else begin
                    if (!present) cursor = 0;
                    entries.insert(cursor, csb_pkg::VALUE_BITS'(val));
                end
            end
            csb_pkg::FN_ATTACH: begin
                if (full) begin
                    v.status = csb_pkg::ST_FULL;
                end else begin
                    if (!present) cursor = entries.size();
                    else cursor++;
                    entries.insert(cursor, csb_pkg::VALUE_BITS'(val));
                end
            end
            csb_pkg::FN_REMOVE: begin
                if (!present) v.status = csb_pkg::ST_NOCUR;
                else entries.delete(cursor);
            end
            default: begin
            end
        endcase
        v.has_cur = cursor < entries.size();
        v.value   = v.has_cur ? csb_pkg::CUR_W'(entries[cursor]) : '0;
        v.count   = csb_pkg::COUNT_W'(entries.size());
        views.push_back(v);
    endfunction

    function void compare_field(string name, logic [csb_pkg::CUR_W-1:0] exp,
                                logic [csb_pkg::CUR_W-1:0] act);
        if (exp !== act) begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp, act);
        end
    endfunction

    function void check_word(logic [csb_pkg::OUT_DATA_W-1:0] word);
        t_cursor_view v;
        if (views.size() == 0) begin
            errors++;
            $display("%0t: result word with no prediction, actual %h", $time, word);
            return;
        end
        v = views.pop_front();
        compare_field("has_current", csb_pkg::CUR_W'(v.has_cur),
                      csb_pkg::CUR_W'(word[csb_pkg::OUT_HAS_BIT]));
        compare_field("current_value", v.value,
                      word[csb_pkg::OUT_VAL_LSB +: csb_pkg::CUR_W]);
        compare_field("entry_count", csb_pkg::CUR_W'(v.count),
                      csb_pkg::CUR_W'(word[csb_pkg::OUT_CNT_LSB +: csb_pkg::COUNT_W]));
        compare_field("status", csb_pkg::CUR_W'(v.status),
                      csb_pkg::CUR_W'(word[csb_pkg::OUT_ST_LSB +: csb_pkg::STATUS_W]));
    endfunction
endclass

module tb_cursor_sequence_buffer;

    localparam int ITEM_TARGET    = 1050;
    localparam int HOLD_CYCLES    = 200;
    localparam int DRAIN_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef enum int {
        SC_FILL,
        SC_DRAIN,
        SC_WALK,
        SC_NOISE,
        SC_CHURN
    } t_scenario;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    logic [csb_pkg::IN_DATA_W-1:0]      s_axis_tdata;   // entry_value
    logic [csb_pkg::FUNC_W-1:0]         s_axis_tuser;   // func
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    // has_current, current_value, entry_count, status, zero pad
    logic [csb_pkg::OUT_DATA_W-1:0]     m_axis_tdata;

    seq_scoreboard sb;
    int            words_sent = 0;
    logic          no_gaps    = 1'b0;
    logic          hold_req   = 1'b0;

    cursor_sequence_buffer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps) return 0;
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [csb_pkg::IN_DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom;
    endfunction

    task automatic send_word(input logic [csb_pkg::FUNC_W-1:0] fn,
                             input logic [csb_pkg::IN_DATA_W-1:0] val);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= val;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_word(fn, val);
        words_sent++;
    endtask

    // stop offering before waiting so the last word is not taken twice
    task automatic wait_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic fill_store();
        int r;
        int guard;
        guard = 0;
        while (sb.entries.size() < csb_pkg::CAPACITY && guard < 200) begin
            r = $urandom_range(0, 99);
            guard++;
            if (r < 45) send_word(csb_pkg::FN_INSERT, pick_value());
            else if (r < 90) send_word(csb_pkg::FN_ATTACH, pick_value());
            else if (r < 95) send_word(csb_pkg::FN_ADVANCE, pick_value());
            else send_word(csb_pkg::FN_START, pick_value());
        end
        send_word(csb_pkg::FN_INSERT, '1);
        send_word(csb_pkg::FN_ATTACH, pick_value());
        send_word(csb_pkg::FN_QUERY, pick_value());
    endtask

    task automatic drain_store();
        int guard;
        guard = 0;
        while (sb.entries.size() > 0 && guard < 400) begin
            guard++;
            if (sb.cursor >= sb.entries.size()) send_word(csb_pkg::FN_START, pick_value());
            else if ($urandom_range(0, 9) < 8) send_word(csb_pkg::FN_REMOVE, pick_value());
            else send_word(csb_pkg::FN_ADVANCE, pick_value());
        end
        send_word(csb_pkg::FN_REMOVE, pick_value());
        send_word(csb_pkg::FN_ADVANCE, pick_value());
    endtask

    task automatic walk_store();
        int steps;
        send_word(csb_pkg::FN_START, pick_value());
        steps = $urandom_range(0, sb.entries.size() + 2);
        repeat (steps) begin
            if ($urandom_range(0, 9) == 0) send_word(csb_pkg::FN_QUERY, pick_value());
            else send_word(csb_pkg::FN_ADVANCE, pick_value());
        end
    endtask

    task automatic churn_store(input int n);
        int r;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 25) send_word(csb_pkg::FN_INSERT, pick_value());
            else if (r < 50) send_word(csb_pkg::FN_ATTACH, pick_value());
            else if (r < 70) send_word(csb_pkg::FN_REMOVE, pick_value());
            else if (r < 85) send_word(csb_pkg::FN_ADVANCE, pick_value());
            else if (r < 92) send_word(csb_pkg::FN_START, pick_value());
            else send_word(csb_pkg::FN_QUERY, pick_value());
        end
    endtask

    // receiver side stalls
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                gap = pick_gap();
                if (gap == 0) begin
                    m_axis_tready <= 1'b1;
                end else begin
                    m_axis_tready <= 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle = 0;
            else idle++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int        round;
        t_scenario kind;
        sb            = new();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty store cases
        send_word(csb_pkg::FN_QUERY, '0);
        send_word(csb_pkg::FN_ADVANCE, 32'h1234_5678);
        send_word(csb_pkg::FN_REMOVE, '1);
        send_word(csb_pkg::FN_START, '0);
        send_word(3'd6, 32'hDEAD_BEEF);
        send_word(3'd7, '1);
        // build, walk off the end, reuse
        send_word(csb_pkg::FN_INSERT, '1);
        send_word(csb_pkg::FN_ATTACH, '0);
        send_word(csb_pkg::FN_ATTACH, 32'h8000_0001);
        send_word(csb_pkg::FN_START, '0);
        send_word(csb_pkg::FN_ADVANCE, '0);
        send_word(csb_pkg::FN_INSERT, 32'h7FFF_FFFE);
        send_word(csb_pkg::FN_ADVANCE, '0);
        send_word(csb_pkg::FN_ADVANCE, '0);
        send_word(csb_pkg::FN_ADVANCE, '0);
        send_word(csb_pkg::FN_ADVANCE, '0);
        send_word(csb_pkg::FN_REMOVE, '0);
        send_word(csb_pkg::FN_ATTACH, 32'h5555_5555);
        send_word(csb_pkg::FN_REMOVE, '0);
        send_word(csb_pkg::FN_INSERT, 32'hAAAA_AAAA);
        send_word(csb_pkg::FN_START, '0);
        send_word(csb_pkg::FN_REMOVE, '0);
        send_word(csb_pkg::FN_QUERY, '1);

        round = 0;
        while (words_sent < ITEM_TARGET) begin
            no_gaps = (round % 7 == 3);
            if (round == 5) hold_req = 1'b1;
            if (round == 9) wait_results();
            if (round % 6 == 1) kind = SC_FILL;
            else if (round % 6 == 4) kind = SC_DRAIN;
            else kind = t_scenario'($urandom_range(SC_WALK, SC_CHURN));
            case (kind)
                SC_FILL:  fill_store();
                SC_DRAIN: drain_store();
                SC_WALK:  walk_store();
                SC_NOISE: begin
                    repeat (20) begin
                        send_word(csb_pkg::FUNC_W'($urandom_range(0, 7)), pick_value());
                    end
                end
                default:  churn_store(40);
            endcase
            round++;
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
